@@ rtl/core/a64dp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64dp_pkg
// shared types and constants of the register data-processing unit
// ----------------------------------------------------------------------------
package a64dp_pkg;

	localparam int REG_COUNT = 32;
	localparam int RF_AW     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	typedef enum logic [1:0] {
		KIND_ARITH = 2'd0,
		KIND_LOGIC = 2'd1,
		KIND_MAC   = 2'd2,
		KIND_LOAD  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SHIFT_LSL = 2'd0,
		SHIFT_LSR = 2'd1,
		SHIFT_ASR = 2'd2,
		SHIFT_ROR = 2'd3
	} shift_t;

	// arith opcodes
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_ADDS = 2'd1;
	localparam logic [1:0] OP_SUB  = 2'd2;
	localparam logic [1:0] OP_SUBS = 2'd3;
	// logical opcodes
	localparam logic [1:0] OP_AND  = 2'd0;
	localparam logic [1:0] OP_ORR  = 2'd1;
	localparam logic [1:0] OP_EOR  = 2'd2;
	localparam logic [1:0] OP_ANDS = 2'd3;

	typedef struct packed {
		kind_t       kind;
		logic        wide;
		logic [1:0]  opcode;
		shift_t      shift_type;
		logic        invert_operand;
		logic [5:0]  shift_count;
		logic [4:0]  src_m;
		logic [4:0]  src_n;
		logic [4:0]  dest;
		logic [4:0]  src_a;
		logic        multiply_subtract;
		logic [63:0] load_value;
	} in_word_t;

	typedef struct packed {
		logic [63:0] written_value;
		logic        flag_n;
		logic        flag_z;
		logic        flag_c;
		logic        flag_v;
	} out_word_t;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} nzcv_t;

	typedef struct packed {
		logic        en;
		logic [4:0]  idx;
		logic [63:0] data;
	} rf_wr_t;

	typedef struct packed {
		logic [63:0] value;
		logic        set_flags;
		nzcv_t       nzcv;
	} alu_out_t;

endpackage

@@ rtl/core/a64_register_data_processing_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64_register_data_processing_unit
// executes one decoded register-form data-processing instruction per word
// against a 64-bit general register file and the nzcv flags
// ----------------------------------------------------------------------------
//  channel   | handshake                  | word
//  ----------+----------------------------+------------------------------
//  instr     | instr_valid / instr_stall  | in_word_t, decoded instruction
//  result    | result_valid / result_stall| out_word_t, value and nzcv
//
//  add/sub, logical and load words: the register file is read at the accept
//  edge and the alu feeds the result register when the execute stage fires;
//  a new word is taken every cycle unless a stalled result or a multiply holds it.
//  multiply words hold the execute stage while one 32x32 multiplier builds
//  the low 64 product bits in three steps, then the accumulate add.
//  reset clears the register file valid bits, the flags and all valids.
//  a stalled result holds the execute stage, which then stalls instr.
// ----------------------------------------------------------------------------
module a64_register_data_processing_unit
	import a64dp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      instr_valid,
	output logic      instr_stall,
	input  in_word_t  instr,
	output logic      result_valid,
	input  logic      result_stall,
	output out_word_t result
);

	localparam logic [1:0] MUL_LL   = 2'd0;
	localparam logic [1:0] MUL_LH   = 2'd1;
	localparam logic [1:0] MUL_HL   = 2'd2;
	localparam logic [1:0] MUL_DONE = 2'd3;

	// execute stage
	in_word_t    item_s1;
	logic        valid_s1;
	logic [63:0] rm_s1, rn_s1, ra_s1;

	// multiply sequencer
	logic [1:0]  mul_cnt_q;
	logic [63:0] prod_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	nzcv_t       flags_q;
	out_word_t   result_q;
	logic        result_valid_q;

	alu_out_t    alu;
	rf_wr_t      wr;
	logic        accept, mac_s1, done_s1, out_free, fire_s1;
	logic [63:0] mac_val, mac_mask, final_val;
	nzcv_t       flags_out;

	// handshake
	assign mac_s1      = (item_s1.kind == KIND_MAC);
	assign done_s1     = !mac_s1 || (mul_cnt_q == MUL_DONE);
	assign out_free    = !result_valid_q || !result_stall;
	assign fire_s1     = valid_s1 && done_s1 && out_free;
	assign instr_stall = valid_s1 && !fire_s1;
	assign accept      = instr_valid && !instr_stall;

	// register file, operands land in the execute stage
	a64dp_regfile u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_m   (instr.src_m),
		.rd_n   (instr.src_n),
		.rd_a   (instr.src_a),
		.wr     (wr),
		.rm_q   (rm_s1),
		.rn_q   (rn_s1),
		.ra_q   (ra_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= instr;
	end

	// shifted, logical and load forms
	a64dp_alu u_alu (
		.instr (item_s1),
		.rm    (rm_s1),
		.rn    (rn_s1),
		.res   (alu)
	);

	// low 64 bits of rn * rm: lo*lo, then the two cross terms into the top half
	always_comb begin
		mul_a = (mul_cnt_q == MUL_HL) ? rn_s1[63:32] : rn_s1[31:0];
		mul_b = (mul_cnt_q == MUL_LH) ? rm_s1[63:32] : rm_s1[31:0];
		mul_p = 64'(mul_a) * 64'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_cnt_q <= MUL_LL;
		end else if (accept) begin
			mul_cnt_q <= MUL_LL;
		end else if (valid_s1 && mac_s1 && mul_cnt_q != MUL_DONE) begin
			mul_cnt_q <= mul_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && mac_s1) begin
			case (mul_cnt_q)
				MUL_LL:  prod_q <= mul_p;
				MUL_LH,
				MUL_HL:  prod_q[63:32] <= prod_q[63:32] + mul_p[31:0];
				default: prod_q <= prod_q;
			endcase
		end
	end

	// accumulate, 32-bit form keeps the low half only
	assign mac_mask  = item_s1.wide ? {64{1'b1}} : {32'b0, 32'hFFFF_FFFF};
	assign mac_val   = (item_s1.multiply_subtract ? (ra_s1 - prod_q) : (ra_s1 + prod_q))
		& mac_mask;
	assign final_val = mac_s1 ? mac_val : alu.value;
	assign flags_out = (!mac_s1 && alu.set_flags) ? alu.nzcv : flags_q;

	// write-back at the edge the result is taken into the output register
	always_comb begin
		wr.en   = fire_s1;
		wr.idx  = item_s1.dest;
		wr.data = final_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (fire_s1) begin
			flags_q <= flags_out;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			result_q.written_value <= final_val;
			result_q.flag_n        <= flags_out.n;
			result_q.flag_z        <= flags_out.z;
			result_q.flag_c        <= flags_out.c;
			result_q.flag_v        <= flags_out.v;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ rtl/core/a64dp_regfile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64dp_regfile
// general register file, three registered read ports, one write port
// ----------------------------------------------------------------------------
module a64dp_regfile
	import a64dp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [4:0]  rd_m,
	input  logic [4:0]  rd_n,
	input  logic [4:0]  rd_a,
	input  rf_wr_t      wr,
	output logic [63:0] rm_q,
	output logic [63:0] rn_q,
	output logic [63:0] ra_q
);

	// one copy per read port, all written alike
	logic [63:0] mem_m [REG_COUNT];
	logic [63:0] mem_n [REG_COUNT];
	logic [63:0] mem_a [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;

	logic             wr_ok, m_ok, n_ok, a_ok;
	logic [RF_AW-1:0] w_i, m_i, n_i, a_i;

	assign wr_ok = wr.en && ({1'b0, wr.idx} < 6'(REG_COUNT));
	assign m_ok  = {1'b0, rd_m} < 6'(REG_COUNT);
	assign n_ok  = {1'b0, rd_n} < 6'(REG_COUNT);
	assign a_ok  = {1'b0, rd_a} < 6'(REG_COUNT);
	assign w_i   = RF_AW'(wr.idx);
	assign m_i   = RF_AW'(rd_m);
	assign n_i   = RF_AW'(rd_n);
	assign a_i   = RF_AW'(rd_a);

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_ok) begin
			vld_q[w_i] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_m[w_i] <= wr.data;
			mem_n[w_i] <= wr.data;
			mem_a[w_i] <= wr.data;
		end
	end

	// write-first: a read at the write edge sees the new word
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_ok && wr.idx == rd_m) rm_q <= wr.data;
			else if (m_ok && vld_q[m_i]) rm_q <= mem_m[m_i];
			else rm_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_ok && wr.idx == rd_n) rn_q <= wr.data;
			else if (n_ok && vld_q[n_i]) rn_q <= mem_n[n_i];
			else rn_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_ok && wr.idx == rd_a) ra_q <= wr.data;
			else if (a_ok && vld_q[a_i]) ra_q <= mem_a[a_i];
			else ra_q <= '0;
		end
	end

endmodule

@@ rtl/core/a64dp_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64dp_alu
// shifted-operand add/sub, logical ops and load select with nzcv
// ----------------------------------------------------------------------------
module a64dp_alu
	import a64dp_pkg::*;
(
	input  in_word_t    instr,
	input  logic [63:0] rm,
	input  logic [63:0] rn,
	output alu_out_t    res
);

	logic [63:0]  mask, x, a, sh, b_add, b_log, r_add, r_log;
	logic [31:0]  x32;
	logic [5:0]   s;
	logic [127:0] rot64;
	logic [63:0]  rot32;
	logic [64:0]  sum;
	logic         cin, carry, ovf;

	always_comb begin
		mask  = instr.wide ? {64{1'b1}} : {32'b0, 32'hFFFF_FFFF};
		x     = rm & mask;
		x32   = rm[31:0];
		a     = rn & mask;
		s     = instr.wide ? instr.shift_count : {1'b0, instr.shift_count[4:0]};
		rot64 = {x, x} >> s;
		rot32 = {x32, x32} >> s[4:0];

		case (instr.shift_type)
			SHIFT_LSL: sh = instr.wide ? (x << s) : {32'b0, x32 << s[4:0]};
			SHIFT_LSR: sh = x >> s;
			SHIFT_ASR: sh = instr.wide ? 64'($signed(x) >>> s)
				: {32'b0, 32'($signed(x32) >>> s[4:0])};
			SHIFT_ROR: sh = instr.wide ? rot64[63:0] : {32'b0, rot32[31:0]};
			default:   sh = x;
		endcase

		// add / sub
		cin   = instr.opcode[1];
		b_add = cin ? (~sh & mask) : sh;
		sum   = {1'b0, a} + {1'b0, b_add} + 65'(cin);
		r_add = sum[63:0] & mask;
		carry = instr.wide ? sum[64] : sum[32];
		ovf   = instr.wide ? ((a[63] ^ r_add[63]) & (b_add[63] ^ r_add[63]))
			: ((a[31] ^ r_add[31]) & (b_add[31] ^ r_add[31]));

		// logical
		b_log = instr.invert_operand ? (~sh & mask) : sh;
		case (instr.opcode)
			OP_ORR:  r_log = a | b_log;
			OP_EOR:  r_log = a ^ b_log;
			default: r_log = a & b_log;
		endcase

		res = '0;
		case (instr.kind)
			KIND_ARITH: begin
				res.value     = r_add;
				res.set_flags = (instr.opcode == OP_ADDS) || (instr.opcode == OP_SUBS);
				res.nzcv.n    = instr.wide ? r_add[63] : r_add[31];
				res.nzcv.z    = (r_add == '0);
				res.nzcv.c    = carry;
				res.nzcv.v    = ovf;
			end
			KIND_LOGIC: begin
				res.value     = r_log;
				res.set_flags = (instr.opcode == OP_ANDS);
				res.nzcv.n    = instr.wide ? r_log[63] : r_log[31];
				res.nzcv.z    = (r_log == '0);
			end
			KIND_LOAD: res.value = instr.load_value;
			default:   res = '0;
		endcase
	end

endmodule

@@ rtl/core/a64dp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64dp_checker
// port-level checks on word flow of the data-processing unit
// ----------------------------------------------------------------------------
module a64dp_checker
	import a64dp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      instr_valid,
	input logic      instr_stall,
	input logic      result_valid,
	input logic      result_stall,
	input out_word_t result
);

	logic [1:0] pend_q;
	logic       acc, dlv;

	assign acc = instr_valid && !instr_stall;
	assign dlv = result_valid && !result_stall;

	// words taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(acc) - 2'(dlv);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("more words in flight than stages");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 2'd0)
		else $error("result word without an accepted instruction");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd0 |-> !instr_stall)
		else $error("instr stalled while unit is empty");

endmodule

bind a64_register_data_processing_unit a64dp_checker u_a64dp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.instr_valid  (instr_valid),
	.instr_stall  (instr_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
